@@ rtl/sobel_conv_relu_maxpool_stream_macros.svh @@
// Assertion macros shared by the stream filter RTL.
`ifndef SOBEL_CONV_RELU_MAXPOOL_STREAM_MACROS_SVH
`define SOBEL_CONV_RELU_MAXPOOL_STREAM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCMP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scmp assertion failed");

// Next-cycle implication, checked outside reset.
`define SCMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scmp assertion failed");

`endif

@@ rtl/scmp_pkg.sv @@
// Shared types, constants and helpers for the Sobel/ReLU/max-pool stream.
package scmp_pkg;

   localparam int CFG_BITS        = 11;
   localparam int SIZE_BITS       = 13;
   localparam int PORT_PIXEL_BITS = 8;
   localparam int WIDE_PIXEL_BITS = 16;
   localparam int VALUE_BITS      = 10;
   localparam int POOL_IDX_BITS   = 9;
   localparam int WIN_COLS        = 2;
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [CFG_BITS-1:0]   CFG_RESET = 11'd1024;
   localparam logic [SIZE_BITS-1:0]  SIZE_MIN  = 13'd4;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = 10'd1023;

   // Per-item control flags carried down the pipeline.
   typedef struct packed {
      logic conv;   // item completes a 3x3 window
      logic x_odd;  // right-hand conv column of a pair
      logic y_odd;  // lower conv row of a pair
      logic last;   // final conv position of the frame
   } pool_ctrl_type;

   // Clear the low bit, then clamp into [4, limit with low bit cleared].
   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [CFG_BITS-1:0] value,
                                                      input logic [SIZE_BITS-1:0] limit);
      logic [SIZE_BITS-1:0] v;
      logic [SIZE_BITS-1:0] lim;
      v   = {2'b00, value & 11'h7FE};
      lim = limit & ~SIZE_BITS'(1);
      if (v < SIZE_MIN) begin
         v = SIZE_MIN;
      end
      if (v > lim) begin
         v = lim;
      end
      return v;
   endfunction

endpackage

@@ rtl/scmp_line_buf.sv @@
// Two line memories holding the previous two lines of pixels.
module scmp_line_buf #(
   parameter int DEPTH      = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [PIXEL_BITS-1:0]        wr_pixel,
   output logic [PIXEL_BITS-1:0]        top_q,
   output logic [PIXEL_BITS-1:0]        mid_q
);

   logic [PIXEL_BITS-1:0] older_mem [DEPTH];
   logic [PIXEL_BITS-1:0] newer_mem [DEPTH];
   logic [PIXEL_BITS-1:0] top_q_ff;
   logic [PIXEL_BITS-1:0] mid_q_ff;

   // Read at accept; data held until the next accept.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_q_ff <= older_mem[rd_addr];
         mid_q_ff <= newer_mem[rd_addr];
      end
   end

   // Push the column down one line.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= mid_q_ff;
         newer_mem[wr_addr] <= wr_pixel;
      end
   end

   assign top_q = top_q_ff;
   assign mid_q = mid_q_ff;

endmodule

@@ rtl/scmp_cell.sv @@
// One window column cell: holds three pixels and their Sobel column weight.
module scmp_cell #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  logic [PIXEL_BITS-1:0]   in_top,
   input  logic [PIXEL_BITS-1:0]   in_mid,
   input  logic [PIXEL_BITS-1:0]   in_bot,
   output logic [PIXEL_BITS-1:0]   out_top,
   output logic [PIXEL_BITS-1:0]   out_mid,
   output logic [PIXEL_BITS-1:0]   out_bot,
   output logic [PIXEL_BITS+1:0]   out_sum
);

   logic [PIXEL_BITS-1:0] top_ff;
   logic [PIXEL_BITS-1:0] mid_ff;
   logic [PIXEL_BITS-1:0] bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
         mid_ff <= '0;
         bot_ff <= '0;
      end else if (shift) begin
         top_ff <= in_top;
         mid_ff <= in_mid;
         bot_ff <= in_bot;
      end
   end

   assign out_top = top_ff;
   assign out_mid = mid_ff;
   assign out_bot = bot_ff;
   // Column weight 1, 2, 1.
   assign out_sum = (PIXEL_BITS+2)'(top_ff) + ((PIXEL_BITS+2)'(mid_ff) << 1)
                  + (PIXEL_BITS+2)'(bot_ff);

endmodule

@@ rtl/scmp_pool.sv @@
// 2x2 max pooling: pair hold, upper-pair store and final maximum.
module scmp_pool #(
   parameter int SLOT_BITS = 9
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 rd_en,
   input  logic [SLOT_BITS-1:0]                 rd_slot,
   input  logic                                 s2_valid,
   input  scmp_pkg::pool_ctrl_type              s2_ctrl,
   input  logic [scmp_pkg::VALUE_BITS-1:0]      s2_value,
   input  logic [SLOT_BITS-1:0]                 s2_slot,
   output logic                                 res_valid,
   output logic [scmp_pkg::VALUE_BITS-1:0]      res_value
);

   localparam int DEPTH = 2 ** SLOT_BITS;

   logic [scmp_pkg::VALUE_BITS-1:0] pair_mem [DEPTH];
   logic [scmp_pkg::VALUE_BITS-1:0] upper_q_ff;
   logic [scmp_pkg::VALUE_BITS-1:0] hold_ff;
   logic [scmp_pkg::VALUE_BITS-1:0] pair_max;
   logic                            live;

   assign live     = s2_valid && s2_ctrl.conv;
   assign pair_max = (hold_ff > s2_value) ? hold_ff : s2_value;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_q_ff <= pair_mem[rd_slot];
      end
   end

   // Upper row: store the pair maximum for the row below.
   always_ff @(posedge clock) begin
      if (advance && live && s2_ctrl.x_odd && !s2_ctrl.y_odd) begin
         pair_mem[s2_slot] <= pair_max;
      end
   end

   // Left conv value of a pair.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else if (advance && live && !s2_ctrl.x_odd) begin
         hold_ff <= s2_value;
      end
   end

   assign res_valid = live && s2_ctrl.x_odd && s2_ctrl.y_odd;
   assign res_value = (upper_q_ff > pair_max) ? upper_q_ff : pair_max;

endmodule

@@ rtl/sobel_conv_relu_maxpool_stream.sv @@
// Top level: streaming Sobel-x filter, rectification and 2x2 max pooling.
// Throughput: one pixel item per cycle; req_stall rises only when both output slots are full.
// A result reaches rsp_ from the pixel that completes its 2x2 block through the stage 1 line
// memory read, the stage 2 Sobel sum register and the pooling compare into the output register.
// Reset: clears positions, window cells, pair hold and output slots; sizes return to 1024.
// Line and pair memories are not cleared; they are always written before they are read.
`include "sobel_conv_relu_maxpool_stream_macros.svh"

module sobel_conv_relu_maxpool_stream #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // pixel items
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [scmp_pkg::PORT_PIXEL_BITS-1:0]     req_pixel,
   // pooled result items
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [scmp_pkg::VALUE_BITS-1:0]          rsp_pooled_value,
   output logic [scmp_pkg::POOL_IDX_BITS-1:0]       rsp_pool_row,
   output logic [scmp_pkg::POOL_IDX_BITS-1:0]       rsp_pool_col,
   output logic                                     rsp_last_of_frame,
   // configuration writes
   input  logic                                     csr_wr_en,
   input  logic [scmp_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [scmp_pkg::CFG_BITS-1:0]            csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);        // column counter
   localparam int WB  = $clog2(MAX_WIDTH + 1);    // width in use
   localparam int RB  = $clog2(MAX_HEIGHT);       // row counter
   localparam int HB  = $clog2(MAX_HEIGHT + 1);   // height in use
   localparam int SW  = $clog2(MAX_WIDTH / 2);    // pooled column / pair slot
   localparam int PRW = $clog2(MAX_HEIGHT / 2);   // pooled row
   localparam int PB  = PIXEL_BITS;
   localparam int CSB = PB + 2;                   // weighted column sum
   localparam int DB  = PB + 3;                   // signed difference of column sums
   localparam int VB  = scmp_pkg::VALUE_BITS;
   localparam int IB  = scmp_pkg::POOL_IDX_BITS;

   // ---------------------------------------------------------------
   // Configuration: keep the sizes already cleaned and clamped.
   // ---------------------------------------------------------------
   logic [WB-1:0] width_ff;
   logic [HB-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(scmp_pkg::eff_size(scmp_pkg::CFG_RESET,
                                             scmp_pkg::SIZE_BITS'(MAX_WIDTH)));
         height_ff <= HB'(scmp_pkg::eff_size(scmp_pkg::CFG_RESET,
                                             scmp_pkg::SIZE_BITS'(MAX_HEIGHT)));
      end else if (csr_wr_en) begin
         case (csr_index)
            scmp_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= WB'(scmp_pkg::eff_size(csr_wdata,
                                                  scmp_pkg::SIZE_BITS'(MAX_WIDTH)));
            end
            scmp_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= HB'(scmp_pkg::eff_size(csr_wdata,
                                                   scmp_pkg::SIZE_BITS'(MAX_HEIGHT)));
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake. The whole pipe advances unless the skid slot is full,
   // so req_stall comes straight from a register.
   // ---------------------------------------------------------------
   logic skid_valid_ff;
   logic advance;
   logic accept;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && advance;

   // ---------------------------------------------------------------
   // Raster position of the next pixel.
   // ---------------------------------------------------------------
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RB-1:0] row_ff;
   logic [RB-1:0] row_in;
   logic          in_frame;
   logic          col_wrap;
   logic          row_wrap;

   assign in_frame = (WB'(col_ff) < width_ff) && (HB'(row_ff) < height_ff);
   assign col_wrap = (WB'(col_ff) + WB'(1)) >= width_ff;
   assign row_wrap = (HB'(row_ff) + HB'(1)) >= height_ff;

   always_comb begin
      col_in = col_ff + CW'(1);
      row_in = row_ff;
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_ff + RB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Flags and indices of the item at the door.
   logic [scmp_pkg::WIDE_PIXEL_BITS-1:0] pixel_wide;
   logic [PB-1:0]                        pixel;
   scmp_pkg::pool_ctrl_type              ctrl_in;
   logic [SW-1:0]                        slot_in;
   logic [PRW-1:0]                       prow_in;

   assign pixel_wide    = scmp_pkg::WIDE_PIXEL_BITS'(req_pixel);
   assign pixel         = pixel_wide[PB-1:0];
   assign ctrl_in.conv  = (row_ff >= RB'(2)) && (col_ff >= CW'(2));
   assign ctrl_in.x_odd = col_ff[0];
   assign ctrl_in.y_odd = row_ff[0];
   assign ctrl_in.last  = (HB'(row_ff) == height_ff - HB'(1))
                       && (WB'(col_ff) == width_ff - WB'(1));
   assign slot_in       = SW'((col_ff - CW'(2)) >> 1);
   assign prow_in       = PRW'((row_ff - RB'(2)) >> 1);

   // ---------------------------------------------------------------
   // Stage 1: line memories read at accept; drop pixels outside the frame.
   // ---------------------------------------------------------------
   logic                    s1_valid_ff;
   scmp_pkg::pool_ctrl_type s1_ctrl_ff;
   logic [PB-1:0]           s1_px_ff;
   logic [CW-1:0]           s1_col_ff;
   logic [SW-1:0]           s1_slot_ff;
   logic [PRW-1:0]          s1_prow_ff;
   logic [PB-1:0]           top_q;
   logic [PB-1:0]           mid_q;
   logic                    s1_move;

   assign s1_move = advance && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && in_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= ctrl_in;
         s1_px_ff   <= pixel;
         s1_col_ff  <= col_ff;
         s1_slot_ff <= slot_in;
         s1_prow_ff <= prow_in;
      end
   end

   scmp_line_buf #(
      .DEPTH      (MAX_WIDTH),
      .PIXEL_BITS (PB)
   ) u_line_buf (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (col_ff),
      .wr_en    (s1_move),
      .wr_addr  (s1_col_ff),
      .wr_pixel (s1_px_ff),
      .top_q    (top_q),
      .mid_q    (mid_q)
   );

   // Window: a chain of column cells, newest first. Shift on every live item.
   logic [PB-1:0]  cell_top [scmp_pkg::WIN_COLS];
   logic [PB-1:0]  cell_mid [scmp_pkg::WIN_COLS];
   logic [PB-1:0]  cell_bot [scmp_pkg::WIN_COLS];
   logic [CSB-1:0] cell_sum [scmp_pkg::WIN_COLS];

   for (genvar i = 0; i < scmp_pkg::WIN_COLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         scmp_cell #(.PIXEL_BITS(PB)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (s1_move),
            .in_top  (top_q),
            .in_mid  (mid_q),
            .in_bot  (s1_px_ff),
            .out_top (cell_top[i]),
            .out_mid (cell_mid[i]),
            .out_bot (cell_bot[i]),
            .out_sum (cell_sum[i])
         );
      end else begin : g_body
         scmp_cell #(.PIXEL_BITS(PB)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (s1_move),
            .in_top  (cell_top[i-1]),
            .in_mid  (cell_mid[i-1]),
            .in_bot  (cell_bot[i-1]),
            .out_top (cell_top[i]),
            .out_mid (cell_mid[i]),
            .out_bot (cell_bot[i]),
            .out_sum (cell_sum[i])
         );
      end
   end

   // Sobel-x: weighted new column minus weighted oldest column, rectified.
   logic [CSB-1:0]        new_sum;
   logic signed [DB-1:0]  diff;
   logic [VB-1:0]         value_in;

   assign new_sum = CSB'(top_q) + (CSB'(mid_q) << 1) + CSB'(s1_px_ff);
   assign diff    = $signed({1'b0, new_sum})
                  - $signed({1'b0, cell_sum[scmp_pkg::WIN_COLS-1]});

   always_comb begin
      if (diff < 0) begin
         value_in = '0;
      end else if (32'(diff) > 32'(scmp_pkg::VALUE_MAX)) begin
         value_in = scmp_pkg::VALUE_MAX;
      end else begin
         value_in = VB'(diff);
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: pooling. The upper pair maximum is read as stage 1 leaves.
   // ---------------------------------------------------------------
   logic                    s2_valid_ff;
   scmp_pkg::pool_ctrl_type s2_ctrl_ff;
   logic [VB-1:0]           s2_value_ff;
   logic [SW-1:0]           s2_slot_ff;
   logic [PRW-1:0]          s2_prow_ff;
   logic                    pair_rd_en;
   logic                    res_valid;
   logic [VB-1:0]           res_value;
   logic                    new_res;

   assign pair_rd_en = s1_move && s1_ctrl_ff.conv && s1_ctrl_ff.x_odd && s1_ctrl_ff.y_odd;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_ctrl_ff  <= s1_ctrl_ff;
         s2_value_ff <= value_in;
         s2_slot_ff  <= s1_slot_ff;
         s2_prow_ff  <= s1_prow_ff;
      end
   end

   scmp_pool #(
      .SLOT_BITS (SW)
   ) u_pool (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rd_en     (pair_rd_en),
      .rd_slot   (s1_slot_ff),
      .s2_valid  (s2_valid_ff),
      .s2_ctrl   (s2_ctrl_ff),
      .s2_value  (s2_value_ff),
      .s2_slot   (s2_slot_ff),
      .res_valid (res_valid),
      .res_value (res_value)
   );

   assign new_res = advance && res_valid;

   // ---------------------------------------------------------------
   // Output register plus skid slot. A result that meets a stalled output
   // parks in the skid slot; the skid slot drains first.
   // ---------------------------------------------------------------
   logic          rsp_valid_ff;
   logic [VB-1:0] rsp_value_ff;
   logic [IB-1:0] rsp_row_ff;
   logic [IB-1:0] rsp_col_ff;
   logic          rsp_last_ff;
   logic [VB-1:0] skid_value_ff;
   logic [IB-1:0] skid_row_ff;
   logic [IB-1:0] skid_col_ff;
   logic          skid_last_ff;
   logic          out_free;
   logic [IB-1:0] res_row;
   logic [IB-1:0] res_col;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign res_row  = IB'(s2_prow_ff);
   assign res_col  = IB'(s2_slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff || new_res;
         skid_valid_ff <= 1'b0;
      end else if (new_res) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_value_ff <= skid_value_ff;
            rsp_row_ff   <= skid_row_ff;
            rsp_col_ff   <= skid_col_ff;
            rsp_last_ff  <= skid_last_ff;
         end else if (new_res) begin
            rsp_value_ff <= res_value;
            rsp_row_ff   <= res_row;
            rsp_col_ff   <= res_col;
            rsp_last_ff  <= s2_ctrl_ff.last;
         end
      end else if (new_res) begin
         skid_value_ff <= res_value;
         skid_row_ff   <= res_row;
         skid_col_ff   <= res_col;
         skid_last_ff  <= s2_ctrl_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pooled_value  = rsp_value_ff;
   assign rsp_pool_row      = rsp_row_ff;
   assign rsp_pool_col      = rsp_col_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // A parked result always sits behind an occupied output register.
   `SCMP_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   // A parked result moves up as soon as the output is taken.
   `SCMP_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall, rsp_valid_ff)
   // The frame's last result sits in the rightmost pooled column.
   `SCMP_ASSERT_NOW(a_last_col, clock, reset, rsp_valid_ff && rsp_last_ff,
                    rsp_col_ff == IB'((width_ff >> 1) - WB'(2)))

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Sobel-x, rectify and 2x2 max-pool pixel stream.
module tb_top;

   // Give up well beyond the slowest plausible run (about 500 pixel items, heavy back-pressure).
   localparam int CYCLE_LIMIT  = 200_000;
   // A pixel passes stage 1, stage 2 and the output register before its pooled item; allow a comfortable margin.
   localparam int DRAIN_CYCLES = 8;
   // Line and frame limits of the instance (default parameters).
   localparam int LINE_MAX     = 1024;
   localparam int FRAME_MAX    = 1024;

   typedef struct packed {
      logic [scmp_pkg::VALUE_BITS-1:0]    value;
      logic [scmp_pkg::POOL_IDX_BITS-1:0] row;
      logic [scmp_pkg::POOL_IDX_BITS-1:0] col;
      logic                               last;
   } pooled_item_type;

   typedef enum {FRAME_RANDOM, FRAME_EXTREME, FRAME_RISING, FRAME_FALLING} frame_kind_type;
   typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   // Size actually in use for a register word: drop the low bit, then clamp into [4, limit with low bit cleared].
   function automatic int unsigned used_size(logic [scmp_pkg::CFG_BITS-1:0] word,
                                             int unsigned limit);
      int unsigned v;
      v = int'(word) & 32'h7FE;
      if (v < 4) begin
         v = 4;
      end
      if (v > (limit & ~32'd1)) begin
         v = limit & ~32'd1;
      end
      return v;
   endfunction

   // Holds its own image of the line stores, window and pooling state, and the
   // queue of pooled items still owed by the block.
   class pool_scoreboard;
      bit [7:0]                      line_older [LINE_MAX];
      bit [7:0]                      line_newer [LINE_MAX];
      bit [7:0]                      win_px [3][2];
      bit [scmp_pkg::VALUE_BITS-1:0] upper_pair [LINE_MAX/2 + 1];
      bit [scmp_pkg::VALUE_BITS-1:0] left_conv;
      int unsigned                   row_pos;
      int unsigned                   col_pos;
      logic [scmp_pkg::CFG_BITS-1:0] width_word;
      logic [scmp_pkg::CFG_BITS-1:0] height_word;
      pooled_item_type               pooled_q[$];
      int unsigned                   predicted;
      int unsigned                   checked;
      int unsigned                   fail_count;

      function new();
         width_word  = scmp_pkg::CFG_RESET;
         height_word = scmp_pkg::CFG_RESET;
      endfunction

      function void set_size(logic [scmp_pkg::CSR_INDEX_BITS-1:0] index,
                             logic [scmp_pkg::CFG_BITS-1:0] word);
         if (index == scmp_pkg::CSR_IMAGE_WIDTH) begin
            width_word = word;
         end else begin
            height_word = word;
         end
      endfunction

      function int unsigned pending();
         return pooled_q.size();
      endfunction

      // Advance the image by one accepted pixel and queue the pooled item it completes.
      function void note_pixel(logic [scmp_pkg::PORT_PIXEL_BITS-1:0] px);
         int unsigned  w;
         int unsigned  h;
         int unsigned  r;
         int unsigned  c;
         int unsigned  y;
         int unsigned  x;
         int unsigned  slot;
         int           sum;
         bit [7:0]     top;
         bit [7:0]     mid;
         bit [scmp_pkg::VALUE_BITS-1:0] conv;
         bit [scmp_pkg::VALUE_BITS-1:0] pair_max;
         pooled_item_type item;
         w = used_size(width_word, LINE_MAX);
         h = used_size(height_word, FRAME_MAX);
         r = row_pos;
         c = col_pos;
         if (r < h && c < w) begin
            top = line_older[c];
            mid = line_newer[c];
            line_older[c] = mid;
            line_newer[c] = px;
            if (r >= 2 && c >= 2) begin
               sum = (int'(top) - int'(win_px[0][0]))
                   + 2 * (int'(mid) - int'(win_px[1][0]))
                   + (int'(px) - int'(win_px[2][0]));
               if (sum < 0) begin
                  sum = 0;
               end
               if (sum > 1023) begin
                  sum = 1023;
               end
               conv = sum[scmp_pkg::VALUE_BITS-1:0];
               y    = r - 2;
               x    = c - 2;
               slot = x / 2;
               if ((x % 2) == 0) begin
                  left_conv = conv;
               end else begin
                  pair_max = (left_conv > conv) ? left_conv : conv;
                  if ((y % 2) == 0) begin
                     upper_pair[slot] = pair_max;
                  end else begin
                     if (upper_pair[slot] > pair_max) begin
                        pair_max = upper_pair[slot];
                     end
                     item.value = pair_max;
                     item.row   = scmp_pkg::POOL_IDX_BITS'(y / 2);
                     item.col   = scmp_pkg::POOL_IDX_BITS'(slot);
                     item.last  = (y == h - 3) && (x == w - 3);
                     pooled_q.push_back(item);
                     predicted++;
                  end
               end
            end
            for (int k = 0; k < 3; k++) begin
               win_px[k][0] = win_px[k][1];
            end
            win_px[0][1] = top;
            win_px[1][1] = mid;
            win_px[2][1] = px;
         end
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      // Match an accepted pooled item against the oldest one owed.
      function void check_result(pooled_item_type got);
         pooled_item_type want;
         if (pooled_q.size() == 0) begin
            fail_count++;
            $display("%0t: pooled item with none expected: expected nothing,", $time);
            $display("   got value %0d row %0d col %0d last %0d",
                     got.value, got.row, got.col, got.last);
            return;
         end
         want = pooled_q.pop_front();
         checked++;
         compare_field("pooled_value", 32'(want.value), 32'(got.value));
         compare_field("pool_row", 32'(want.row), 32'(got.row));
         compare_field("pool_col", 32'(want.col), 32'(got.col));
         compare_field("last_of_frame", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and the block's ports, all known from time zero.
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [scmp_pkg::PORT_PIXEL_BITS-1:0] req_pixel = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [scmp_pkg::VALUE_BITS-1:0]      rsp_pooled_value;
   logic [scmp_pkg::POOL_IDX_BITS-1:0]   rsp_pool_row;
   logic [scmp_pkg::POOL_IDX_BITS-1:0]   rsp_pool_col;
   logic                                 rsp_last_of_frame;
   logic                                 csr_wr_en = 1'b0;
   logic [scmp_pkg::CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [scmp_pkg::CFG_BITS-1:0]        csr_wdata = '0;

   pool_scoreboard  sb;
   pooled_item_type seen_item;
   int unsigned     cycle_count  = 0;
   int unsigned     pixels_sent  = 0;
   int unsigned     size_writes  = 0;
   int              burst_left   = 0;
   stall_mode_type  stall_mode   = STALL_NONE;
   int unsigned     stall_left   = 0;

   always #5 clock = ~clock;

   sobel_conv_relu_maxpool_stream i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pooled_value  (rsp_pooled_value),
      .rsp_pool_row      (rsp_pool_row),
      .rsp_pool_col      (rsp_pool_col),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Observe every handshake at the rising edge. Register writes, pixel
   // items and pooled items are all taken from the same sampled values.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            sb.set_size(csr_index, csr_wdata);
         end
         if (req_valid && !req_stall) begin
            sb.note_pixel(req_pixel);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_item = {rsp_pooled_value, rsp_pool_row, rsp_pool_col, rsp_last_of_frame};
            sb.check_result(seen_item);
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d pooled items outstanding",
                  cycle_count, sb.pending());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver back-pressure: switch between free flow, coin tosses, a fixed
   // duty pattern and heavy stalling, each held for a random stretch.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(32, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_COIN: begin
            rsp_stall <= ($urandom_range(0, 1) == 1);
         end
         STALL_PERIODIC: begin
            rsp_stall <= ((cycle_count % 5) < 3);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sender tasks.
   // ------------------------------------------------------------------

   // Send a run of pixel items. Patterned kinds use the column within a line of
   // the given length. The sender works in bursts with random gaps between them;
   // some bursts are long enough to leave whole stretches without idling.
   task automatic send_run(int unsigned cols, int unsigned count, frame_kind_type kind);
      int unsigned gap;
      logic [scmp_pkg::PORT_PIXEL_BITS-1:0] px;
      for (int unsigned i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
               @(negedge clock);
               req_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
         end
         burst_left--;
         case (kind)
            FRAME_RISING: begin
               px = ((i % cols) < cols / 2) ? 8'd0 : 8'd255;
            end
            FRAME_FALLING: begin
               px = ((i % cols) < cols / 2) ? 8'd255 : 8'd0;
            end
            FRAME_EXTREME: begin
               px = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            end
            default: begin
               px = scmp_pkg::PORT_PIXEL_BITS'($urandom_range(0, 255));
            end
         endcase
         @(negedge clock);
         req_valid <= 1'b1;
         req_pixel <= px;
         // Hold the item until the block takes it.
         @(posedge clock);
         while (req_stall !== 1'b0) begin
            @(posedge clock);
         end
         pixels_sent++;
      end
   endtask

   // Drop valid and wait until every owed pooled item has come out, then let
   // the pipeline empty of pixels that complete no block.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(logic [scmp_pkg::CSR_INDEX_BITS-1:0] index,
                             logic [scmp_pkg::CFG_BITS-1:0] word);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= word;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      size_writes++;
   endtask

   task automatic set_frame(logic [scmp_pkg::CFG_BITS-1:0] width_word,
                            logic [scmp_pkg::CFG_BITS-1:0] height_word);
      write_size(scmp_pkg::CSR_IMAGE_WIDTH, width_word);
      write_size(scmp_pkg::CSR_IMAGE_HEIGHT, height_word);
   endtask

   // Register word for a wanted even size: now and then set the ignored low
   // bit, or for the smallest size use a word below the minimum.
   function automatic logic [scmp_pkg::CFG_BITS-1:0] size_word(int unsigned want);
      case ($urandom_range(0, 5))
         0: begin
            return scmp_pkg::CFG_BITS'(want | 1);
         end
         1: begin
            return (want == 4) ? scmp_pkg::CFG_BITS'($urandom_range(0, 3))
                               : scmp_pkg::CFG_BITS'(want);
         end
         default: begin
            return scmp_pkg::CFG_BITS'(want);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned rand_pixels;
      int unsigned start_pooled;

      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest frame: width word 5 loses its low bit. A dark-to-bright edge
      // gives the largest pooled value, the reverse edge rectifies to zero.
      set_frame(11'd5, 11'd4);
      send_run(4, 16, FRAME_RISING);
      send_run(4, 16, FRAME_FALLING);
      settle_block();

      // Words below the minimum are used as 4.
      set_frame(11'd0, 11'd1);
      send_run(4, 16, FRAME_EXTREME);
      settle_block();

      // All-ones height word clamps to the tallest frame: four lines give one
      // pooled item that is not the last. Shrinking to 4 then drops line 4 and
      // a fresh 4x4 frame follows.
      set_frame(11'd4, 11'd2047);
      send_run(4, 16, FRAME_RANDOM);
      settle_block();
      write_size(scmp_pkg::CSR_IMAGE_HEIGHT, 11'd4);
      send_run(4, 4 + 16, FRAME_RANDOM);
      settle_block();

      // Width shrinks mid-frame: one full 10x8 frame fills every store entry in
      // use, then stop at row 3 column 7. With width 6 that pixel is dropped and
      // the frame finishes at the new width.
      set_frame(11'd10, 11'd8);
      send_run(10, 80, FRAME_RANDOM);
      send_run(10, 37, FRAME_RANDOM);
      settle_block();
      write_size(scmp_pkg::CSR_IMAGE_WIDTH, 11'd6);
      send_run(6, 1 + 4 * 6, FRAME_RANDOM);
      settle_block();

      // Height shrinks mid-frame: stop after five lines of a 6x8 frame; with
      // height 4 the rest of line 5 is dropped and a fresh 6x4 frame follows.
      send_run(6, 48, FRAME_RANDOM);
      send_run(6, 30, FRAME_RANDOM);
      settle_block();
      write_size(scmp_pkg::CSR_IMAGE_HEIGHT, 11'd4);
      send_run(6, 6 + 24, FRAME_RANDOM);
      settle_block();

      // Random frames of small even sizes until enough pixels and pooled items.
      rand_pixels  = 0;
      start_pooled = sb.predicted;
      while (rand_pixels < 120 || sb.predicted - start_pooled < 12) begin
         w = 2 * $urandom_range(2, 12);
         h = 2 * $urandom_range(2, 6);
         set_frame(size_word(w), size_word(h));
         send_run(w, w * h, ($urandom_range(0, 4) == 0) ? FRAME_EXTREME : FRAME_RANDOM);
         settle_block();
         rand_pixels += w * h;
      end

      // Wait out anything still owed, then a little longer for strays.
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d pixel items over %0d size writes, %0d pooled items checked, %0d failures",
               pixels_sent, size_writes, sb.checked, sb.fail_count);
      $display("run: small frames, clamped tall frame, odd and out-of-range words, mid-frame shrinks");
      if (sb.fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
